// ----- hw/rtl/siq_pkg.sv -----
// ----------------------------------------------------------------------------
// siq_pkg
// Shared sizes, op codes and sequencer states for the sorted insert queue.
// ----------------------------------------------------------------------------
package siq_pkg;

  localparam int DEPTH = 16;
  localparam int IDX_W = $clog2(DEPTH);
  localparam int CNT_W = $clog2(DEPTH + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam int VAL_W = 32;
  localparam int OP_W  = 2;
  localparam int ECNT_W = 5;

  localparam int IN_FIELDS_W  = OP_W + VAL_W;
  localparam int IN_TDATA_W   = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = VAL_W + 1 + ECNT_W + 1;
  localparam int OUT_TDATA_W  = ((OUT_FIELDS_W + 7) / 8) * 8;

  typedef enum logic [OP_W-1:0] {
    OP_INSERT = 2'd0,
    OP_APPEND = 2'd1,
    OP_REMOVE = 2'd2
  } op_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_EXEC,
    ST_SCAN,
    ST_SCAN_CMP,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_PLACE,
    ST_HEAD_WAIT,
    ST_FINISH
  } state_t;

endpackage

// ----- hw/rtl/siq_ram.sv -----
// ----------------------------------------------------------------------------
// siq_ram
// Generic single-write, single-read RAM with a registered read port.
// ----------------------------------------------------------------------------
module siq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- hw/rtl/sorted_insert_queue.sv -----
// ----------------------------------------------------------------------------
// sorted_insert_queue
// Bounded queue of signed values held in a circular RAM. Insert places a
// value at its sorted place, append adds at the tail, remove drops the head.
// ----------------------------------------------------------------------------
//  channel  | dir | word contents
//  ---------+-----+------------------------------------------------------------
//  s_axis   | in  | op, value: one command word
//  m_axis   | out | head_value, head_valid, entry_count, dropped: one status word
//
//  append, remove, no-op and refused writes need no scan or shift; insert walks
//  the entries it scans and then moves one RAM access at a time, as set by
//  the single RAM read port and one shared signed comparator.
//  one command in flight at a time; s_tready is high only when the sequencer idles.
//  a finished word waits in the output register while the next command is taken.
//  rst is synchronous; the queue comes out empty, RAM contents are not cleared.
// ----------------------------------------------------------------------------
module sorted_insert_queue (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  output logic                            s_tready,
  input  logic [siq_pkg::IN_TDATA_W-1:0]  s_tdata,  // op[1:0], value[33:2]
  output logic                            m_tvalid,
  input  logic                            m_tready,
  output logic [siq_pkg::OUT_TDATA_W-1:0] m_tdata   // head_value[31:0], head_valid[32],
                                                     // entry_count[37:33], dropped[38]
);

  import siq_pkg::*;

  state_t state, state_next;

  op_t              op;
  logic [VAL_W-1:0] val;
  logic [CNT_W-1:0] occ, occ_next;
  logic [IDX_W-1:0] head_ptr, head_ptr_next;
  logic [VAL_W-1:0] head_val, head_val_next;
  logic [CNT_W-1:0] idx, idx_next;
  logic [CNT_W-1:0] pos, pos_next;
  logic             drop, drop_next;

  logic [VAL_W-1:0] out_head;
  logic             out_hvalid;
  logic [CNT_W-1:0] out_cnt;
  logic             out_drop;

  logic [CNT_W-1:0] log_idx;
  logic [IDX_W-1:0] addr;
  logic             ram_we, ram_re;
  logic [VAL_W-1:0] ram_wdata, ram_rdata;
  logic [VAL_W-1:0] cmp_a, cmp_b;
  logic             lt;
  logic             full;
  logic             accept;
  logic             out_free;
  logic             out_load;

  // logical position to RAM address, head_ptr marks logical zero
  function automatic logic [IDX_W-1:0] phys(input logic [IDX_W-1:0] base,
                                             input logic [CNT_W-1:0] ofs);
    logic [SUM_W-1:0] sum;
    sum = SUM_W'(base) + SUM_W'(ofs);
    if (sum >= SUM_W'(DEPTH)) begin
      sum = sum - SUM_W'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

  assign addr     = phys(head_ptr, log_idx);
  assign lt       = $signed(cmp_a) < $signed(cmp_b);
  assign full     = (occ == CNT_W'(DEPTH));
  assign s_tready = (state == ST_IDLE);
  assign accept   = s_tvalid && s_tready;
  assign out_free = !m_tvalid || m_tready;
  assign out_load = (state == ST_FINISH) && out_free;

  siq_ram #(
    .WIDTH (VAL_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (addr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (addr),
    .rdata (ram_rdata)
  );

  // next state
  always_comb begin
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          state_next = ST_EXEC;
        end
      end
      ST_EXEC: begin
        case (op)
          OP_INSERT: begin
            if (full) begin
              state_next = ST_FINISH;
            end else if (occ == '0 || lt) begin
              state_next = ST_SHIFT_RD;
            end else begin
              state_next = ST_SCAN;
            end
          end
          OP_APPEND: state_next = ST_FINISH;
          OP_REMOVE: begin
            state_next = (occ != '0) ? ST_HEAD_WAIT : ST_FINISH;
          end
          default: state_next = ST_FINISH;
        endcase
      end
      ST_SCAN: begin
        state_next = (idx < occ) ? ST_SCAN_CMP : ST_SHIFT_RD;
      end
      ST_SCAN_CMP: begin
        state_next = lt ? ST_SCAN : ST_SHIFT_RD;
      end
      ST_SHIFT_RD: begin
        state_next = (idx > pos) ? ST_SHIFT_WR : ST_PLACE;
      end
      ST_SHIFT_WR:  state_next = ST_SHIFT_RD;
      ST_PLACE:     state_next = ST_FINISH;
      ST_HEAD_WAIT: state_next = ST_FINISH;
      ST_FINISH: begin
        if (out_free) begin
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // datapath controls
  always_comb begin
    log_idx       = idx;
    ram_we        = 1'b0;
    ram_re        = 1'b0;
    ram_wdata     = val;
    cmp_a         = val;
    cmp_b         = head_val;
    occ_next      = occ;
    head_ptr_next = head_ptr;
    head_val_next = head_val;
    idx_next      = idx;
    pos_next      = pos;
    drop_next     = drop;
    case (state)
      ST_IDLE: begin
        if (accept) begin
          drop_next = 1'b0;
        end
      end
      ST_EXEC: begin
        case (op)
          OP_INSERT: begin
            if (full) begin
              drop_next = 1'b1;
            end else if (occ == '0 || lt) begin
              pos_next = '0;
              idx_next = occ;
            end else begin
              idx_next = CNT_W'(1);
            end
          end
          OP_APPEND: begin
            if (full) begin
              drop_next = 1'b1;
            end else begin
              log_idx  = occ;
              ram_we   = 1'b1;
              occ_next = occ + CNT_W'(1);
              if (occ == '0) begin
                head_val_next = val;
              end
            end
          end
          OP_REMOVE: begin
            if (occ != '0) begin
              // fetch the second entry, it becomes the head
              log_idx       = CNT_W'(1);
              ram_re        = 1'b1;
              head_ptr_next = addr;
              occ_next      = occ - CNT_W'(1);
            end
          end
          default: ;
        endcase
      end
      ST_SCAN: begin
        if (idx < occ) begin
          ram_re = 1'b1;
        end else begin
          pos_next = idx;
          idx_next = occ;
        end
      end
      ST_SCAN_CMP: begin
        cmp_a = ram_rdata;
        cmp_b = val;
        if (lt) begin
          idx_next = idx + CNT_W'(1);
        end else begin
          pos_next = idx;
          idx_next = occ;
        end
      end
      ST_SHIFT_RD: begin
        if (idx > pos) begin
          log_idx = idx - CNT_W'(1);
          ram_re  = 1'b1;
        end
      end
      ST_SHIFT_WR: begin
        ram_we    = 1'b1;
        ram_wdata = ram_rdata;
        idx_next  = idx - CNT_W'(1);
      end
      ST_PLACE: begin
        log_idx  = pos;
        ram_we   = 1'b1;
        occ_next = occ + CNT_W'(1);
        if (pos == '0) begin
          head_val_next = val;
        end
      end
      ST_HEAD_WAIT: begin
        head_val_next = ram_rdata;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_IDLE;
      occ      <= '0;
      head_ptr <= '0;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      occ      <= occ_next;
      head_ptr <= head_ptr_next;
      if (out_load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      op  <= op_t'(s_tdata[OP_W-1:0]);
      val <= s_tdata[OP_W +: VAL_W];
    end
    head_val <= head_val_next;
    idx      <= idx_next;
    pos      <= pos_next;
    drop     <= drop_next;
    if (out_load) begin
      out_head   <= (occ != '0) ? head_val : '0;
      out_hvalid <= (occ != '0);
      out_cnt    <= occ;
      out_drop   <= drop;
    end
  end

  assign m_tdata = {(OUT_TDATA_W - OUT_FIELDS_W)'(0), out_drop, ECNT_W'(out_cnt),
                    out_hvalid, out_head};

  a_occ_bound: assert property (@(posedge clk) disable iff (rst)
    occ <= CNT_W'(DEPTH))
    else $error("occupancy above depth");

  a_accept_starts: assert property (@(posedge clk) disable iff (rst)
    accept |=> state == ST_EXEC)
    else $error("accepted command did not start");

  a_idle_holds_occ: assert property (@(posedge clk) disable iff (rst)
    state == ST_IDLE |=> $stable(occ))
    else $error("occupancy moved while idle");

  a_drop_full: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && out_drop |-> out_cnt == CNT_W'(DEPTH))
    else $error("dropped reported with room left");

  a_head_flag: assert property (@(posedge clk) disable iff (rst)
    m_tvalid |-> out_hvalid == (out_cnt != '0))
    else $error("head valid disagrees with count");

endmodule

// ----- sim/sorted_insert_queue_check.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_insert_queue_check
// Watches both stream channels of the queue, keeps its own copy of the queue
// contents to work out the status word due for every accepted command, and
// compares each status word that leaves the block, field by field, in order.
// ----------------------------------------------------------------------------
module sorted_insert_queue_check (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            s_tvalid,
  input  logic                            s_tready,
  input  logic [siq_pkg::IN_TDATA_W-1:0]  s_tdata,  // op[1:0], value[33:2]
  input  logic                            m_tvalid,
  input  logic                            m_tready,
  input  logic [siq_pkg::OUT_TDATA_W-1:0] m_tdata,  // head_value[31:0], head_valid[32],
                                                    // entry_count[37:33], dropped[38]
  output int                              errors,
  output int                              pending,
  output int                              commands,
  output int                              refused,
  output int                              empty_removes
);

  import siq_pkg::*;

  localparam int REPORT_LIMIT = 20;

  // lowest field last so the packed layout matches m_tdata
  typedef struct packed {
    logic              dropped;
    logic [ECNT_W-1:0] entry_count;
    logic              head_valid;
    logic [VAL_W-1:0]  head_value;
  } status_t;

  logic signed [VAL_W-1:0] slots [DEPTH];
  int                      fill;
  status_t                 due_status [$];

  function automatic status_t apply_command(input logic [OP_W-1:0] op,
                                            input logic signed [VAL_W-1:0] v);
    status_t st;
    int      pos;
    st = '0;
    case (op)
      OP_INSERT, OP_APPEND: begin
        if (fill >= DEPTH) begin
          st.dropped = 1'b1;
        end else if (op == OP_INSERT) begin
          // head is compared alone, the scan starts behind it
          if (fill == 0 || v < slots[0]) begin
            pos = 0;
          end else begin
            pos = 1;
            while (pos < fill && slots[pos] < v) pos++;
          end
          for (int i = fill; i > pos; i--) slots[i] = slots[i-1];
          slots[pos] = v;
          fill++;
        end else begin
          slots[fill] = v;
          fill++;
        end
      end
      OP_REMOVE: begin
        if (fill > 0) begin
          for (int i = 1; i < fill; i++) slots[i-1] = slots[i];
          fill--;
        end
      end
      default: ;
    endcase
    st.head_valid  = (fill > 0);
    st.head_value  = (fill > 0) ? slots[0] : '0;
    st.entry_count = fill[ECNT_W-1:0];
    return st;
  endfunction

  task automatic check_field(input string field, input logic signed [VAL_W-1:0] want,
                             input logic signed [VAL_W-1:0] seen);
    if (want !== seen) begin
      errors++;
      if (errors <= REPORT_LIMIT)
        $display("%0t: %s expected %0d, got %0d", $time, field, want, seen);
    end
  endtask

  always @(posedge clk) begin
    status_t                 seen;
    status_t                 want;
    logic [OP_W-1:0]         op;
    logic signed [VAL_W-1:0] v;
    if (rst) begin
      fill = 0;
      due_status.delete();
      errors = 0;
      pending = 0;
      commands = 0;
      refused = 0;
      empty_removes = 0;
    end else begin
      if (m_tvalid && m_tready) begin
        seen = status_t'(m_tdata[OUT_FIELDS_W-1:0]);
        if (due_status.size() == 0) begin
          errors++;
          if (errors <= REPORT_LIMIT)
            $display("%0t: no status word expected, got %h", $time, seen);
        end else begin
          want = due_status.pop_front();
          check_field("head_value", want.head_value, seen.head_value);
          check_field("head_valid", want.head_valid, seen.head_valid);
          check_field("entry_count", want.entry_count, seen.entry_count);
          check_field("dropped", want.dropped, seen.dropped);
        end
      end
      if (s_tvalid && s_tready) begin
        op = s_tdata[OP_W-1:0];
        v  = s_tdata[OP_W +: VAL_W];
        if (op == OP_REMOVE && fill == 0) empty_removes++;
        want = apply_command(op, v);
        if (want.dropped) refused++;
        due_status.push_back(want);
        commands++;
      end
      pending = due_status.size();
    end
  end

endmodule

// ----- sim/sorted_insert_queue_test.sv -----
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// sorted_insert_queue_test
// Drives command words into the sorted insert queue: a short directed run
// over empty, full, equal-value and out-of-order cases, then random fill and
// drain stretches under four pacing modes and one long receiver hold-off.
// ----------------------------------------------------------------------------
module sorted_insert_queue_test;
  import siq_pkg::*;

  localparam logic [OP_W-1:0]       OP_NOP         = 2'd3;
  localparam logic signed [VAL_W-1:0] VAL_MIN      = 32'h8000_0000;
  localparam logic signed [VAL_W-1:0] VAL_MAX      = 32'h7fff_ffff;
  localparam int                    PHASES         = 8;
  localparam int                    PHASE_WORDS    = 119;
  localparam int                    HOLD_CYCLES    = 300;
  localparam int                    TAIL_CYCLES    = 100;
  localparam int                    WATCHDOG_LIMIT = 4000;

  typedef enum {TREND_FILL, TREND_DRAIN, TREND_MIXED} trend_t;

  logic                   clk = 1'b0;
  logic                   rst = 1'b1;
  logic                   s_tvalid = 1'b0;
  logic                   s_tready;
  logic [IN_TDATA_W-1:0]  s_tdata = '0;
  logic                   m_tvalid;
  logic                   m_tready = 1'b0;
  logic [OUT_TDATA_W-1:0] m_tdata;

  int errors, pending, commands, refused, empty_removes;
  int tx_idle_pct = 0;
  int rx_stall_pct = 0;
  int hold_asks = 0;
  int hold_seen = 0;
  int hold_left = 0;
  int quiet_cycles = 0;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  sorted_insert_queue uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

  sorted_insert_queue_check checker_i (
    .clk           (clk),
    .rst           (rst),
    .s_tvalid      (s_tvalid),
    .s_tready      (s_tready),
    .s_tdata       (s_tdata),
    .m_tvalid      (m_tvalid),
    .m_tready      (m_tready),
    .m_tdata       (m_tdata),
    .errors        (errors),
    .pending       (pending),
    .commands      (commands),
    .refused       (refused),
    .empty_removes (empty_removes)
  );

  // receiver: random stalls, or a long hold-off when one is requested
  always @(posedge clk) begin
    if (rst) begin
      m_tready <= 1'b0;
      hold_left <= 0;
    end else if (hold_asks != hold_seen) begin
      hold_seen <= hold_asks;
      hold_left <= HOLD_CYCLES;
      m_tready <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left <= hold_left - 1;
      m_tready <= 1'b0;
    end else begin
      m_tready <= ($urandom_range(0, 99) >= rx_stall_pct);
    end
  end

  always @(posedge clk) begin
    if (rst || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles == WATCHDOG_LIMIT) begin
      $display("sorted_insert_queue test failed");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // called at a rising edge, returns at the edge where the word was taken
  task automatic send_word(input logic [OP_W-1:0] op, input logic signed [VAL_W-1:0] v);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(IN_TDATA_W - IN_FIELDS_W){1'b0}}, v, op};
    do @(negedge clk); while (!s_tready);
    @(posedge clk);
  endtask

  task automatic wait_drained();
    s_tvalid <= 1'b0;
    do @(negedge clk); while (pending != 0);
    @(posedge clk);
  endtask

  // narrow range for duplicates, corner values, and full-width noise
  function automatic logic signed [VAL_W-1:0] pick_value();
    int r;
    r = $urandom_range(0, 99);
    if (r < 30) return 32'($urandom_range(0, 16)) - 32'd8;
    if (r < 40) begin
      case ($urandom_range(0, 5))
        0:       return VAL_MIN;
        1:       return VAL_MAX;
        2:       return -1;
        3:       return 0;
        4:       return VAL_MIN + 1;
        default: return VAL_MAX - 1;
      endcase
    end
    return $urandom();
  endfunction

  function automatic logic [OP_W-1:0] pick_op(input trend_t trend);
    int r;
    int ins_lim, app_lim, rem_lim;
    r = $urandom_range(0, 99);
    case (trend)
      TREND_FILL: begin
        ins_lim = 50; app_lim = 80; rem_lim = 96;
      end
      TREND_DRAIN: begin
        ins_lim = 15; app_lim = 25; rem_lim = 96;
      end
      default: begin
        ins_lim = 35; app_lim = 55; rem_lim = 96;
      end
    endcase
    if (r < ins_lim) return OP_INSERT;
    if (r < app_lim) return OP_APPEND;
    if (r < rem_lim) return OP_REMOVE;
    return OP_NOP;
  endfunction

  initial begin
    trend_t trend;
    int     trend_left;
    trend = TREND_FILL;
    trend_left = 0;
    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    send_word(OP_REMOVE, 0);
    send_word(OP_NOP, -1);
    send_word(OP_INSERT, 0);
    send_word(OP_INSERT, VAL_MIN);
    send_word(OP_INSERT, VAL_MAX);
    send_word(OP_INSERT, 0);
    // out-of-order tail, then inserts that must stop at the first not-less entry
    send_word(OP_APPEND, -5);
    send_word(OP_INSERT, 3);
    send_word(OP_INSERT, VAL_MIN);
    send_word(OP_INSERT, -6);
    for (int i = 0; i < 6; i++) send_word(OP_APPEND, pick_value());
    send_word(OP_APPEND, VAL_MIN);
    send_word(OP_APPEND, VAL_MAX);
    send_word(OP_INSERT, 1);
    send_word(OP_APPEND, 2);
    send_word(OP_NOP, 0);
    send_word(OP_REMOVE, 0);
    wait_drained();

    // output held off while commands keep coming: input side must stall
    hold_asks <= hold_asks + 1;
    for (int i = 0; i < 12; i++) send_word(pick_op(TREND_MIXED), pick_value());
    wait_drained();

    for (int p = 0; p < PHASES; p++) begin
      case (p % 4)
        0:       begin tx_idle_pct = 0;  rx_stall_pct <= 0;  end
        1:       begin tx_idle_pct = 86; rx_stall_pct <= 0;  end
        2:       begin tx_idle_pct = 0;  rx_stall_pct <= 86; end
        default: begin tx_idle_pct = 19; rx_stall_pct <= 19; end
      endcase
      for (int k = 0; k < PHASE_WORDS; k++) begin
        if (trend_left == 0) begin
          trend = trend_t'($urandom_range(0, 2));
          trend_left = $urandom_range(10, 40);
        end
        trend_left--;
        send_word(pick_op(trend), pick_value());
      end
      wait_drained();
    end

    repeat (TAIL_CYCLES) @(posedge clk);
    $display("%0d commands under four pacing modes and one long output hold-off",
             commands);
    $display("%0d writes refused on a full queue, %0d removes on an empty queue",
             refused, empty_removes);
    if (errors == 0)
      $display("sorted_insert_queue test passed");
    else
      $display("sorted_insert_queue test failed");
    $finish;
  end

endmodule

// ----- files.f -----
hw/rtl/siq_pkg.sv
hw/rtl/siq_ram.sv
hw/rtl/sorted_insert_queue.sv
sim/sorted_insert_queue_check.sv
sim/sorted_insert_queue_test.sv
